>>> rtl/ntc_thermistor_temperature_assert.svh
// ----------------------------------------------------------------------------
// NTC thermistor temperature: assertion macros
// Shared assertion macros for the thermistor pipeline modules.
// ----------------------------------------------------------------------------
`ifndef NTC_THERMISTOR_TEMPERATURE_ASSERT_SVH
`define NTC_THERMISTOR_TEMPERATURE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NTC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ntc assertion failed");
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ntc assertion failed");
`else
`define NTC_ASSERT_IMPL(lbl, ante, cons)
`define NTC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature: package
// Widths, constants and shared types of the thermistor pipeline.
// ----------------------------------------------------------------------------
package ntc_pkg;
    localparam int VOLT_W     = 13;
    localparam int BETA_W     = 14;
    localparam int OHM_W      = 20;
    localparam int FIELD_W    = 15;
    localparam int APB_ADDR_W = 5;
    localparam int NUM_W      = OHM_W + VOLT_W;
    localparam int LOG_FRAC   = 24;
    localparam int NORM_BITS  = 30;
    localparam int MANT_W     = NORM_BITS + 1;
    localparam int TOP_W      = 6;
    localparam int LOG_W      = TOP_W + LOG_FRAC;
    localparam int LOG_ROUNDS = LOG_FRAC;
    localparam int DEN_W      = 46;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    typedef enum logic [2:0] {
        REG_BETA    = 3'd0,
        REG_NTC_REF = 3'd1,
        REG_DIVIDER = 3'd2,
        REG_SUPPLY  = 3'd3,
        REG_VMIN    = 3'd4,
        REG_VMAX    = 3'd5
    } t_reg;

    typedef struct packed {
        logic valid;
        logic cold;
        logic hot;
    } t_tag;

    typedef struct packed {
        logic [BETA_W-1:0] beta;
        logic [OHM_W-1:0]  ntc_ref;
        logic [OHM_W-1:0]  divider;
        logic [VOLT_W-1:0] supply;
        logic [VOLT_W-1:0] vmin;
        logic [VOLT_W-1:0] vmax;
    } t_cfg;
endpackage

>>> rtl/ntc_apb_regs.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature: configuration registers
// APB register file holding the thermistor and divider settings.
// ----------------------------------------------------------------------------
module ntc_apb_regs import ntc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);
    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                REG_BETA:    n_cfg.beta    = pwdata[BETA_W-1:0];
                REG_NTC_REF: n_cfg.ntc_ref = pwdata[OHM_W-1:0];
                REG_DIVIDER: n_cfg.divider = pwdata[OHM_W-1:0];
                REG_SUPPLY:  n_cfg.supply  = pwdata[VOLT_W-1:0];
                REG_VMIN:    n_cfg.vmin    = pwdata[VOLT_W-1:0];
                REG_VMAX:    n_cfg.vmax    = pwdata[VOLT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BETA:    prdata = 32'(r_cfg.beta);
            REG_NTC_REF: prdata = 32'(r_cfg.ntc_ref);
            REG_DIVIDER: prdata = 32'(r_cfg.divider);
            REG_SUPPLY:  prdata = 32'(r_cfg.supply);
            REG_VMIN:    prdata = 32'(r_cfg.vmin);
            REG_VMAX:    prdata = 32'(r_cfg.vmax);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beta    <= BETA_W'(3435);
            r_cfg.ntc_ref <= OHM_W'(10000);
            r_cfg.divider <= OHM_W'(10000);
            r_cfg.supply  <= VOLT_W'(3300);
            r_cfg.vmin    <= VOLT_W'(16);
            r_cfg.vmax    <= VOLT_W'(3000);
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule

>>> rtl/ntc_log2.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature: pipelined log2
// Two-lane base-2 logarithm in Q24, one squaring round per stage.
// ----------------------------------------------------------------------------
module ntc_log2 import ntc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tag             i_tag,
    input  logic [NUM_W-1:0] i_num,
    input  logic [NUM_W-1:0] i_den,
    output t_tag             o_tag,
    output logic [LOG_W-1:0] o_log_num,
    output logic [LOG_W-1:0] o_log_den
);
    localparam int LANES = 2;

    t_tag               r_tag  [0:LOG_ROUNDS];
    logic [TOP_W-1:0]   r_top  [0:LANES-1][0:LOG_ROUNDS];
    logic [MANT_W-1:0]  r_m    [0:LANES-1][0:LOG_ROUNDS];
    logic [LOG_FRAC-1:0] r_frac [0:LANES-1][0:LOG_ROUNDS];
    logic [NUM_W-1:0]   lane_in [0:LANES-1];

    assign lane_in[0] = i_num;
    assign lane_in[1] = i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LOG_ROUNDS; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k <= LOG_ROUNDS; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [TOP_W-1:0]          n_top;
        logic [NUM_W+NORM_BITS-1:0] wide;

        always_comb begin
            n_top = '0;
            for (int i = 1; i < NUM_W; i++) begin
                if (lane_in[l][i]) n_top = TOP_W'(i);
            end
            wide = {lane_in[l], NORM_BITS'(0)} >> n_top;
        end

        always_ff @(posedge i_clk) begin
            r_top[l][0]  <= n_top;
            r_m[l][0]    <= wide[MANT_W-1:0];
            r_frac[l][0] <= '0;
        end

        for (genvar k = 1; k <= LOG_ROUNDS; k++) begin : g_round
            logic [2*MANT_W-1:0] sq;
            logic [MANT_W:0]     sh;
            logic [MANT_W-1:0]   n_m;
            logic                n_bit;

            always_comb begin
                sq    = (2*MANT_W)'(r_m[l][k-1]) * (2*MANT_W)'(r_m[l][k-1]);
                sh    = sq[NORM_BITS+MANT_W:NORM_BITS];
                n_bit = sh[MANT_W];
                n_m   = n_bit ? sh[MANT_W:1] : sh[MANT_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                r_m[l][k]    <= n_m;
                r_top[l][k]  <= r_top[l][k-1];
                r_frac[l][k] <= {r_frac[l][k-1][LOG_FRAC-2:0], n_bit};
            end
        end
    end

    assign o_tag     = r_tag[LOG_ROUNDS];
    assign o_log_num = {r_top[0][LOG_ROUNDS], r_frac[0][LOG_ROUNDS]};
    assign o_log_den = {r_top[1][LOG_ROUNDS], r_frac[1][LOG_ROUNDS]};
endmodule

>>> rtl/ntc_div.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature: pipelined divider
// Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ntc_div import ntc_pkg::*; #(
    parameter int QB = 18,
    parameter int NW = 62
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tag          i_tag,
    input  logic [NW-1:0] i_dvd,
    input  logic [DEN_W-1:0] i_d,
    output t_tag          o_tag,
    output logic [QB-1:0] o_quo
);
    t_tag             r_tag [0:QB];
    logic [DEN_W-1:0] r_rem [0:QB];
    logic [QB-1:0]    r_low [0:QB];
    logic [DEN_W-1:0] r_d   [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QB; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int k = 1; k <= QB; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DEN_W'(i_dvd >> QB);
        r_low[0] <= i_dvd[QB-1:0];
        r_d[0]   <= i_d;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        always_comb begin
            trial = {r_rem[k-1], r_low[k-1][QB-1]};
            ge    = trial >= {1'b0, r_d[k-1]};
            n_rem = ge ? DEN_W'(trial - {1'b0, r_d[k-1]}) : trial[DEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_low[k] <= {r_low[k-1][QB-2:0], ge};
            r_d[k]   <= r_d[k-1];
        end
    end

    assign o_tag = r_tag[QB];
    assign o_quo = r_low[QB];
endmodule

>>> rtl/ntc_water.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature: water estimate
// Three-segment linear map from sensor to water temperature.
// ----------------------------------------------------------------------------
`include "ntc_thermistor_temperature_assert.svh"
module ntc_water import ntc_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [FRAC_BITS+6:0] i_sensor,
    output logic                 o_valid,
    output logic [FRAC_BITS+6:0] o_sensor,
    output logic [FRAC_BITS+6:0] o_water
);
    localparam int TW = FRAC_BITS + 7;
    localparam int PW = TW + 7;
    localparam int RS = PW + 7;
    localparam int MW = PW + 1;
    localparam int QW = 2 * PW + 1;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RS) / 64'd100) + 64'd1);
    localparam logic [TW-1:0] HOT   = TW'(99 << FRAC_BITS);
    localparam logic [TW-1:0] LOW_T = TW'(35 << FRAC_BITS);
    localparam logic [TW-1:0] MID_T = TW'(65 << FRAC_BITS);
    localparam logic [TW:0]   ONE   = (TW+1)'(1 << FRAC_BITS);
    localparam logic [TW:0]   HALF  = (TW+1)'(1 << (FRAC_BITS - 1));

    logic          r_v1, r_v2, r_v3;
    logic [TW-1:0] r_t1, r_t2, r_t3;
    logic          r_low1, r_low2, r_mid1, r_mid2;
    logic [PW-1:0] r_prod;
    logic [QW-1:0] r_qp;
    logic [TW-1:0] r_w;

    logic [PW-1:0] n_prod;
    logic [QW-1:0] n_qp;
    logic [TW:0]   quo;
    logic [TW:0]   sum;
    logic [TW-1:0] n_w;

    function automatic logic is_mid(input logic [TW-1:0] t);
        return t < MID_T;
    endfunction

    always_comb begin
        n_prod = (is_mid(i_sensor) ? PW'(117) : PW'(110)) * PW'(i_sensor) + PW'(50);
    end

    assign n_qp = QW'(r_prod) * QW'(RECIP);

    always_comb begin
        quo = r_qp[QW-1:RS];
        if (r_low2) begin
            sum = {1'b0, r_t2} + ONE;
        end else if (r_mid2) begin
            sum = quo + ONE;
        end else begin
            sum = quo + HALF;
        end
        n_w = (sum > {1'b0, HOT}) ? HOT : sum[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1   <= i_sensor;
        r_low1 <= i_sensor < LOW_T;
        r_mid1 <= is_mid(i_sensor);
        r_prod <= n_prod;
        r_t2   <= r_t1;
        r_low2 <= r_low1;
        r_mid2 <= r_mid1;
        r_qp   <= n_qp;
        r_t3   <= r_t2;
        r_w    <= n_w;
    end

    assign o_valid  = r_v3;
    assign o_sensor = r_t3;
    assign o_water  = r_w;

    `NTC_ASSERT_IMPL(a_water_not_below, r_v3, r_w >= r_t3)
    `NTC_ASSERT_IMPL(a_water_capped, r_v3, r_w <= HOT)
endmodule

>>> rtl/ntc_thermistor_temperature.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature
// Beta-equation thermometer with a water temperature estimate.
// ----------------------------------------------------------------------------
// Usage: drive a divider voltage in millivolts on i_voltage_mv and raise start;
// the item is taken at each clock edge where start is high and busy is low.
// busy is high only while reset is applied and in the cycle after it.
// One result per item appears on o_sensor_temp and o_water_temp, both
// unsigned fixed point with FRAC_BITS fraction bits, for the single cycle in
// which o_done is high. Results leave in the order the items came in.
// The path to o_done runs through the 24 squaring rounds of the logarithm and
// the one-bit-per-stage divider, among the other pipeline registers.
// Throughput is one item per cycle while busy is low; no item depends on an earlier one.
// The receiver cannot stall, so nothing is held back at the output.
// Reset clears all valid bits and loads the default register values. The user
// must write settings via the APB port while no item is in flight; unenforced.
// ----------------------------------------------------------------------------
`include "ntc_thermistor_temperature_assert.svh"
module ntc_thermistor_temperature import ntc_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VOLT_W-1:0]     i_voltage_mv,
    output logic                  o_done,
    output logic [FIELD_W-1:0]    o_sensor_temp,
    output logic [FIELD_W-1:0]    o_water_temp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int TW    = FRAC_BITS + 7;
    localparam int QB    = FRAC_BITS + 10;
    localparam int LNP_W = 60;
    localparam int LNM_W = 30;
    localparam int BT_W  = 21;
    localparam int LNK_W = 45;
    localparam int NK_W  = 29;
    localparam int DS_W  = 47;
    localparam int D1_W  = 56;
    localparam int NF_W  = NK_W + LOG_FRAC;
    localparam int NW    = NF_W + FRAC_BITS + 1;
    localparam logic [TW-1:0] HOT   = TW'(99 << FRAC_BITS);
    localparam logic [QB-1:0] HOT_Q = QB'(99 << FRAC_BITS);
    localparam logic [QB-1:0] C0    = QB'(((27315 << FRAC_BITS) + 50) / 100);
    localparam logic [14:0]   K_BETA = 15'd29815;

    t_cfg cfg;
    logic r_run;

    ntc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy = !r_run;

    // Front end: clamp, special cases, resistance products.
    t_tag              n_s1_tag, r_s1_tag, r_s2_tag;
    logic [VOLT_W-1:0] n_v, r_v, n_diff, r_diff;
    logic [NUM_W-1:0]  r_num, r_den;

    always_comb begin
        if (i_voltage_mv < cfg.vmin) begin
            n_v = cfg.vmin;
        end else if (i_voltage_mv > cfg.vmax) begin
            n_v = cfg.vmax;
        end else begin
            n_v = i_voltage_mv;
        end
        n_s1_tag.valid = start && r_run;
        n_s1_tag.cold  = (n_v >= cfg.supply) || (cfg.ntc_ref == '0);
        n_s1_tag.hot   = (n_v == '0) || (cfg.divider == '0);
        n_diff         = cfg.supply - n_v;
    end

    // Logarithms.
    t_tag             log_tag;
    logic [LOG_W-1:0] log_num, log_den;

    ntc_log2 u_log2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (r_s2_tag),
        .i_num     (r_num),
        .i_den     (r_den),
        .o_tag     (log_tag),
        .o_log_num (log_num),
        .o_log_den (log_den)
    );

    // Natural log and beta denominator.
    t_tag             r_s3_tag, r_s4_tag, r_s5_tag, r_s6_tag, r_s7_tag, r_s8_tag, r_s9_tag;
    t_tag             n_s7_tag, n_s9_tag;
    logic             r_neg3, r_neg4, r_neg5, r_neg6;
    logic [LOG_W-1:0] r_mag;
    logic [LNP_W-1:0] r_lnp;
    logic [LNP_W:0]   lnr;
    logic [LNM_W-1:0] r_lnm;
    logic [BT_W-1:0]  r_bterm;
    logic [LNK_W-1:0] r_lnk;
    logic [NK_W-1:0]  r_n6, r_n7, r_n8;
    logic [DS_W-1:0]  dsum;
    logic [DEN_W-1:0] r_d7, r_d8;
    logic [D1_W-1:0]  r_d1001;
    logic [NF_W-1:0]  nfull;
    logic [NW-1:0]    n_dvd, r_dvd;
    logic [DEN_W-1:0] r_dvd_d;

    assign lnr = {1'b0, r_lnp} + (LNP_W+1)'(64'd1 << 29);

    always_comb begin
        n_s7_tag = r_s6_tag;
        dsum = r_neg6 ? DS_W'({r_bterm, LOG_FRAC'(0)}) - DS_W'(r_lnk)
                      : DS_W'({r_bterm, LOG_FRAC'(0)}) + DS_W'(r_lnk);
        if (dsum[DS_W-1] || (dsum == '0)) n_s7_tag.hot = 1'b1;
    end

    always_comb begin
        n_s9_tag = r_s8_tag;
        nfull    = {r_n8, LOG_FRAC'(0)};
        if (D1_W'(nfull) >= r_d1001) n_s9_tag.hot = 1'b1;
        n_dvd = (NW'(nfull) << FRAC_BITS) + NW'(r_d8 >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_diff  <= n_diff;
        r_num   <= NUM_W'(cfg.divider) * NUM_W'(r_v);
        r_den   <= NUM_W'(cfg.ntc_ref) * NUM_W'(r_diff);
        r_neg3  <= log_num < log_den;
        r_mag   <= (log_num < log_den) ? log_den - log_num : log_num - log_den;
        r_neg4  <= r_neg3;
        r_lnp   <= LNP_W'(r_mag) * LNP_W'(LN2_Q30);
        r_neg5  <= r_neg4;
        r_lnm   <= lnr[LNP_W-1:NORM_BITS];
        r_neg6  <= r_neg5;
        r_bterm <= BT_W'(cfg.beta) * BT_W'(7'd100);
        r_lnk   <= LNK_W'(K_BETA) * LNK_W'(r_lnm);
        r_n6    <= NK_W'(K_BETA) * NK_W'(cfg.beta);
        r_d7    <= dsum[DEN_W-1:0];
        r_n7    <= r_n6;
        r_d1001 <= D1_W'(r_d7) * D1_W'(10'd1001);
        r_d8    <= r_d7;
        r_n8    <= r_n7;
        r_dvd   <= n_dvd;
        r_dvd_d <= r_d8;
    end

    // Kelvin quotient.
    t_tag          div_tag;
    logic [QB-1:0] quo;

    ntc_div #(
        .QB (QB),
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s9_tag),
        .i_dvd   (r_dvd),
        .i_d     (r_dvd_d),
        .o_tag   (div_tag),
        .o_quo   (quo)
    );

    // Celsius and clamp.
    logic          r_s_valid;
    logic [TW-1:0] n_s, r_s;
    logic [QB-1:0] tdiff;

    always_comb begin
        tdiff = quo - C0;
        if (div_tag.cold) begin
            n_s = '0;
        end else if (div_tag.hot) begin
            n_s = HOT;
        end else if (quo <= C0) begin
            n_s = '0;
        end else if (tdiff > HOT_Q) begin
            n_s = HOT;
        end else begin
            n_s = tdiff[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_s1_tag  <= '0;
            r_s2_tag  <= '0;
            r_s3_tag  <= '0;
            r_s4_tag  <= '0;
            r_s5_tag  <= '0;
            r_s6_tag  <= '0;
            r_s7_tag  <= '0;
            r_s8_tag  <= '0;
            r_s9_tag  <= '0;
            r_s_valid <= 1'b0;
        end else begin
            r_run     <= 1'b1;
            r_s1_tag  <= n_s1_tag;
            r_s2_tag  <= r_s1_tag;
            r_s3_tag  <= log_tag;
            r_s4_tag  <= r_s3_tag;
            r_s5_tag  <= r_s4_tag;
            r_s6_tag  <= r_s5_tag;
            r_s7_tag  <= n_s7_tag;
            r_s8_tag  <= r_s7_tag;
            r_s9_tag  <= n_s9_tag;
            r_s_valid <= div_tag.valid;
        end
    end

    // Water estimate and output registers.
    logic          w_valid;
    logic [TW-1:0] w_sensor, w_water;

    ntc_water #(
        .FRAC_BITS (FRAC_BITS)
    ) u_water (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s_valid),
        .i_sensor (r_s),
        .o_valid  (w_valid),
        .o_sensor (w_sensor),
        .o_water  (w_water)
    );

    assign o_done        = w_valid;
    assign o_sensor_temp = FIELD_W'(w_sensor);
    assign o_water_temp  = FIELD_W'(w_water);

    `NTC_ASSERT_NEXT(a_cold_gives_zero, div_tag.valid && div_tag.cold, r_s == '0)
    `NTC_ASSERT_NEXT(a_hot_gives_top, div_tag.valid && div_tag.hot && !div_tag.cold, r_s == HOT)
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NTC thermistor temperature: testbench
// Feeds divider voltages on i_voltage_mv with start and checks the sensor and
// water temperatures against a fixed-point model of the beta equation.
// Starts with a short list of voltages and settings, then runs random
// settings and random voltages with random gaps between items.
// ----------------------------------------------------------------------------
module testbench import ntc_pkg::*; ();
    localparam int FRAC      = 8;
    localparam int LATENCY   = 48 + FRAC;
    localparam int IDLE_LIM  = 5000;
    localparam int N_RANDOM  = 1880;

    typedef enum int { ROW_ITEM, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_reg              idx;
        int unsigned       value;
        bit                typed;
        logic [FIELD_W-1:0] sensor;
        logic [FIELD_W-1:0] water;
    } t_row;

    typedef struct {
        logic [FIELD_W-1:0] sensor;
        logic [FIELD_W-1:0] water;
    } t_temps;

    typedef longint unsigned t_u64;

    localparam logic [FIELD_W-1:0] HOT_Q   = FIELD_W'(99 << FRAC);
    localparam logic [FIELD_W-1:0] ONE_Q   = FIELD_W'(1 << FRAC);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [VOLT_W-1:0]     i_voltage_mv;
    logic                  o_done;
    logic [FIELD_W-1:0]    o_sensor_temp;
    logic [FIELD_W-1:0]    o_water_temp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    ntc_thermistor_temperature #(.FRAC_BITS(FRAC)) dut (.*);

    longint unsigned beta_k, ref_ohm, div_ohm, supply, vlo, vhi;
    t_temps          pending_temps[$];
    int              errors = 0;
    int              n_items = 0;
    int              n_temps = 0;
    int              n_cfg = 0;
    int              idle_cycles = 0;
    bit              no_gaps = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned log2_q24(longint unsigned n);
        longint unsigned t, m, frac;
        int top;
        t = n;
        top = 0;
        frac = 0;
        while (t > 1) begin
            t = t >> 1;
            top++;
        end
        if (top >= NORM_BITS) m = n >> (top - NORM_BITS);
        else m = n << (NORM_BITS - top);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> NORM_BITS;
            frac = frac << 1;
            if (m >= (64'd2 << NORM_BITS)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (t_u64'(top) << LOG_FRAC) | frac;
    endfunction

    function automatic longint unsigned sensor_q(longint unsigned v);
        longint unsigned num, den, mag, n, q, rem, tk, c0;
        longint l2, lnv, d;
        if (v >= supply || ref_ohm == 0) return 0;
        num = div_ohm * v;
        if (num == 0) return 99 << FRAC;
        den = ref_ohm * (supply - v);
        l2 = longint'(log2_q24(num)) - longint'(log2_q24(den));
        mag = (l2 < 0) ? t_u64'(-l2) : t_u64'(l2);
        lnv = longint'((mag * 64'd744261118 + (64'd1 << 29)) >> 30);
        if (l2 < 0) lnv = -lnv;
        d = longint'(beta_k * 100 * (64'd1 << LOG_FRAC)) + 29815 * lnv;
        if (d <= 0) return 99 << FRAC;
        n = (64'd29815 * beta_k) << LOG_FRAC;
        q = n / t_u64'(d);
        if (q > 1000) return 99 << FRAC;
        rem = n % t_u64'(d);
        tk = (q << FRAC) + (((rem << FRAC) + t_u64'(d) / 2)
             / t_u64'(d));
        c0 = ((64'd27315 << FRAC) + 50) / 100;
        if (tk <= c0) return 0;
        tk = tk - c0;
        return (tk > (99 << FRAC)) ? (99 << FRAC) : tk;
    endfunction

    function automatic t_temps predict_temps(logic [VOLT_W-1:0] volts);
        longint unsigned v, s, w;
        t_temps r;
        v = volts;
        if (v < vlo) v = vlo;
        else if (v > vhi) v = vhi;
        s = sensor_q(v);
        if (s < (35 << FRAC)) w = s + (1 << FRAC);
        else if (s < (65 << FRAC)) w = (117 * s + 50) / 100 + (1 << FRAC);
        else w = (110 * s + 50) / 100 + ((1 << FRAC) >> 1);
        if (w > (99 << FRAC)) w = 99 << FRAC;
        r.sensor = FIELD_W'(s);
        r.water  = FIELD_W'(w);
        return r;
    endfunction

    task automatic pause_gap();
        int g, pick;
        pick = $urandom_range(99);
        if (no_gaps || pick < 55) g = 0;
        else if (pick < 93) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 80);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_voltage(logic [VOLT_W-1:0] v, bit typed, t_temps typed_temps);
        i_voltage_mv <= v;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        idle_cycles = 0;
        n_items++;
        pending_temps.push_back(typed ? typed_temps : predict_temps(v));
        pause_gap();
    endtask

    task automatic write_reg(t_reg idx, int unsigned value);
        start <= 1'b0;
        wait (pending_temps.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        idle_cycles = 0;
        n_cfg++;
        case (idx)
            REG_BETA:    beta_k  = value & 32'h3FFF;
            REG_NTC_REF: ref_ohm = value & 32'hFFFFF;
            REG_DIVIDER: div_ohm = value & 32'hFFFFF;
            REG_SUPPLY:  supply  = value & 32'h1FFF;
            REG_VMIN:    vlo     = value & 32'h1FFF;
            default:     vhi     = value & 32'h1FFF;
        endcase
    endtask

    function automatic t_row item_row(int unsigned v);
        t_row r;
        r = '{ROW_ITEM, REG_BETA, v, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic t_row typed_row(int unsigned v, logic [FIELD_W-1:0] s,
                                       logic [FIELD_W-1:0] w);
        t_row r;
        r = '{ROW_ITEM, REG_BETA, v, 1'b1, s, w};
        return r;
    endfunction

    function automatic t_row cfg_row(t_reg idx, int unsigned v);
        t_row r;
        r = '{ROW_CFG, idx, v, 1'b0, '0, '0};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_temps exp_t;
        idle_cycles++;
        if (i_rst_n && o_done) begin
            idle_cycles = 0;
            if (pending_temps.size() == 0) begin
                $display("%0t: result with nothing expected: sensor %0d water %0d",
                         $time, o_sensor_temp, o_water_temp);
                errors++;
            end else begin
                exp_t = pending_temps.pop_front();
                n_temps++;
                if (o_sensor_temp !== exp_t.sensor) begin
                    $display("%0t: sensor_temp expected %0d actual %0d",
                             $time, exp_t.sensor, o_sensor_temp);
                    errors++;
                end
                if (o_water_temp !== exp_t.water) begin
                    $display("%0t: water_temp expected %0d actual %0d",
                             $time, exp_t.water, o_water_temp);
                    errors++;
                end
            end
        end
        if (idle_cycles > IDLE_LIM) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIM);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_temps tt;
        int     per_phase;
        start = 1'b0;
        i_voltage_mv = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        beta_k = 3435;
        ref_ohm = 10000;
        div_ohm = 10000;
        supply = 3300;
        vlo = 16;
        vhi = 3000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{item_row(0), item_row(8191), item_row(1500), item_row(16),
                 item_row(3000), item_row(1650), item_row(600),
                 cfg_row(REG_VMIN, 0), cfg_row(REG_VMAX, 8191),
                 typed_row(0, HOT_Q, HOT_Q), typed_row(8191, 0, ONE_Q),
                 typed_row(3300, 0, ONE_Q), item_row(3299), item_row(1),
                 cfg_row(REG_BETA, 1000), item_row(200), cfg_row(REG_BETA, 10000),
                 item_row(2500), cfg_row(REG_NTC_REF, 0), typed_row(1000, 0, ONE_Q),
                 cfg_row(REG_NTC_REF, 1000000), cfg_row(REG_DIVIDER, 0),
                 typed_row(1000, HOT_Q, HOT_Q), cfg_row(REG_DIVIDER, 100),
                 item_row(1000), cfg_row(REG_SUPPLY, 5000), cfg_row(REG_VMIN, 3000),
                 cfg_row(REG_VMAX, 100), item_row(50), item_row(5000)};
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].idx, rows[i].value);
            end else begin
                tt.sensor = rows[i].sensor;
                tt.water  = rows[i].water;
                send_voltage(VOLT_W'(rows[i].value), rows[i].typed, tt);
            end
        end

        per_phase = N_RANDOM / 8;
        for (int ph = 0; ph < 8; ph++) begin
            int unsigned sup;
            bit wild;
            wild = (ph == 5);
            sup = (ph == 1) ? 1000 : (ph == 2) ? 5000 : $urandom_range(1000, 5000);
            write_reg(REG_BETA, wild ? $urandom_range(16383) :
                      (ph == 1) ? 1000 : (ph == 2) ? 10000 : $urandom_range(1000, 10000));
            write_reg(REG_NTC_REF, wild ? $urandom_range(20'hFFFFF) :
                      (ph == 1) ? 100 : (ph == 2) ? 1000000 : $urandom_range(100, 1000000));
            write_reg(REG_DIVIDER, wild ? $urandom_range(20'hFFFFF) :
                      (ph == 1) ? 1000000 : (ph == 2) ? 100 : $urandom_range(100, 1000000));
            write_reg(REG_SUPPLY, wild ? $urandom_range(13'h1FFF) : sup);
            write_reg(REG_VMIN, (ph == 3) ? 0 : wild ? $urandom_range(13'h1FFF) :
                      $urandom_range(0, 200));
            write_reg(REG_VMAX, (ph == 3) ? 8191 : wild ? $urandom_range(13'h1FFF) :
                      $urandom_range(sup / 2, sup - 1));
            no_gaps = (ph == 4);
            repeat (per_phase) begin
                if ($urandom_range(9) < 8)
                    send_voltage(VOLT_W'($urandom_range(0, supply + 100)), 1'b0, tt);
                else
                    send_voltage(VOLT_W'($urandom), 1'b0, tt);
            end
        end
        no_gaps = 0;

        start <= 1'b0;
        wait (pending_temps.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d voltages and checked %0d results over %0d register writes,",
                 n_items, n_temps, n_cfg);
        $display("covering clamp windows, cold and hot limits and random settings.");
        if (errors == 0 && pending_temps.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_apb_regs.sv
rtl/ntc_log2.sv
rtl/ntc_div.sv
rtl/ntc_water.sv
rtl/ntc_thermistor_temperature.sv
test/testbench.sv
